[rtl/assert_macros.svh]
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPLIES(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPLIES(label, clk, rst, cond, prop)

`define ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

[rtl/dortm_pkg.sv]
`default_nettype none

package dortm_pkg;

  localparam int ADDR_BITS = 20;
  localparam int COL_BITS = 15;
  localparam int ROW_BITS = ADDR_BITS - COL_BITS;
  localparam int LANES = 4;
  localparam int LANE_BITS = 2;
  localparam int WORD_BITS = ADDR_BITS - LANE_BITS;
  localparam int WORDS = 1 << WORD_BITS;

  localparam int ACTIVE_COUNT = 100;
  localparam int ACTIVE_MIN = 10;

  localparam logic [7:0] CAS_RESET = 8'd5;
  localparam logic [7:0] WRITE_RESET = 8'd4;
  localparam logic [7:0] PRE_RESET = 8'd5;
  localparam logic [7:0] BEAT_RESET = 8'd1;

  localparam logic [2:0] SIZE_BYTE = 3'd1;
  localparam logic [2:0] SIZE_HALF = 3'd2;
  localparam logic [2:0] SIZE_WORD = 3'd4;

  localparam logic CMD_READ = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  typedef enum logic [1:0] {
    CFG_CAS   = 2'd0,
    CFG_WRITE = 2'd1,
    CFG_PRE   = 2'd2,
    CFG_BEAT  = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    PH_IDLE = 1'b0,
    PH_OPEN = 1'b1
  } row_phase_t;

  typedef enum logic [1:0] {
    BP_NONE  = 2'd0,
    BP_FIRST = 2'd1,
    BP_BURST = 2'd2
  } burst_phase_t;

  typedef struct packed {
    logic [9:0]  latency;
    logic        row_miss;
    logic [47:0] total_time;
    logic [31:0] precharges;
  } timing_res_t;

endpackage

`default_nettype wire

[rtl/dortm_timing.sv]
`default_nettype none

module dortm_timing import dortm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [7:0]          cfg_data,
  input  wire logic                acc,
  input  wire logic                wr,
  input  wire logic [ROW_BITS-1:0] row,
  input  wire logic [7:0]          blen,
  output timing_res_t              res
);

  logic [7:0] cas_latency;
  logic [7:0] write_latency;
  logic [7:0] precharge_time;
  logic [7:0] beat_time;

  logic [ROW_BITS-1:0] open_row;
  row_phase_t          row_phase;
  burst_phase_t        burst_phase, burst_phase_next;
  logic [7:0]          beats_left, beats_left_next;
  logic                read_seen, read_seen_next;
  logic                write_seen, write_seen_next;
  logic [47:0]         time_sum;
  logic [31:0]         precharge_total;

  burst_phase_t phase_eff;
  logic [7:0]   beats_eff;
  logic [7:0]   col;
  logic         seen;
  logic         miss;
  logic [7:0]   col_part;
  logic [9:0]   lat;

  always_ff @(posedge clk) begin
    if (rst) begin
      cas_latency    <= CAS_RESET;
      write_latency  <= WRITE_RESET;
      precharge_time <= PRE_RESET;
      beat_time      <= BEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_CAS:   cas_latency    <= cfg_data;
        CFG_WRITE: write_latency  <= cfg_data;
        CFG_PRE:   precharge_time <= cfg_data;
        CFG_BEAT:  beat_time      <= cfg_data;
      endcase
    end
  end

  assign phase_eff = (burst_phase == BP_NONE && blen > 8'd1) ? BP_FIRST : burst_phase;
  assign beats_eff = (burst_phase == BP_NONE && blen > 8'd1) ? blen : beats_left;
  assign col  = wr ? write_latency : cas_latency;
  assign seen = wr ? write_seen : read_seen;
  assign miss = row_phase == PH_IDLE || row != open_row || ACTIVE_COUNT < ACTIVE_MIN;

  // burst state
  always_comb begin
    burst_phase_next = phase_eff;
    beats_left_next  = beats_eff;
    read_seen_next   = read_seen;
    write_seen_next  = write_seen;
    unique case (phase_eff)
      BP_FIRST: begin
        burst_phase_next = BP_BURST;
        beats_left_next  = beats_eff - 8'd1;
        if (wr) write_seen_next = 1'b1;
        else    read_seen_next  = 1'b1;
      end
      BP_BURST: begin
        beats_left_next = beats_eff - 8'd1;
        if (beats_left_next == 8'd0) begin
          burst_phase_next = BP_NONE;
          if (wr) write_seen_next = 1'b0;
          else    read_seen_next  = 1'b0;
        end
      end
      default: begin
        burst_phase_next = BP_NONE;
        read_seen_next   = 1'b0;
        write_seen_next  = 1'b0;
      end
    endcase
  end

  // latency of this access
  always_comb begin
    unique case (phase_eff)
      BP_FIRST: col_part = seen ? beat_time : col;
      BP_BURST: col_part = beat_time;
      default:  col_part = col;
    endcase
    lat = 10'(col_part);
    if (miss) lat = lat + 10'(precharge_time) + 10'(col);
  end

  assign res.latency    = lat;
  assign res.row_miss   = miss;
  assign res.total_time = time_sum + 48'(lat);
  assign res.precharges = precharge_total + 32'(miss);

  always_ff @(posedge clk) begin
    if (rst) begin
      open_row        <= '0;
      row_phase       <= PH_IDLE;
      burst_phase     <= BP_NONE;
      beats_left      <= 8'd0;
      read_seen       <= 1'b0;
      write_seen      <= 1'b0;
      time_sum        <= 48'd0;
      precharge_total <= 32'd0;
    end else if (acc) begin
      open_row        <= row;
      row_phase       <= PH_OPEN;
      burst_phase     <= burst_phase_next;
      beats_left      <= beats_left_next;
      read_seen       <= read_seen_next;
      write_seen      <= write_seen_next;
      time_sum        <= res.total_time;
      precharge_total <= res.precharges;
    end
  end

endmodule

`default_nettype wire

[rtl/dortm_bytes.sv]
`default_nettype none

module dortm_bytes import dortm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 acc,
  input  wire logic                 wr,
  input  wire logic [ADDR_BITS-1:0] addr,
  input  wire logic [31:0]          wdata,
  input  wire logic [2:0]           size,
  input  wire logic                 good,
  output logic      [31:0]          rdata
);

  logic [LANE_BITS-1:0] off;
  logic [WORD_BITS-1:0] word;
  logic [7:0]           q [LANES];

  logic [LANE_BITS-1:0] rd_off;
  logic [2:0]           rd_size;
  logic                 rd_en;

  assign off  = addr[LANE_BITS-1:0];
  assign word = addr[ADDR_BITS-1:LANE_BITS];

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    logic [7:0]           mem [WORDS];
    logic [LANE_BITS-1:0] idx;
    logic                 used;
    logic [WORD_BITS-1:0] widx;
    logic [31:0]          shifted;

    assign idx     = LANE_BITS'(k) - off;
    assign used    = good && ({1'b0, idx} < size);
    assign widx    = word + WORD_BITS'(LANE_BITS'(k) < off);
    assign shifted = wdata >> {idx, 3'b000};

    always_ff @(posedge clk) begin
      if (acc && wr == CMD_WRITE && used) mem[widx] <= shifted[7:0];
      if (acc && wr == CMD_READ) q[k] <= mem[widx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_en <= 1'b0;
    end else if (acc) begin
      rd_en <= wr == CMD_READ && good;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      rd_off  <= off;
      rd_size <= size;
    end
  end

  // gather the bytes back into little-endian order
  always_comb begin
    rdata = 32'd0;
    for (int i = 0; i < LANES; i++) begin
      if (rd_en && 3'(i) < rd_size) rdata[8*i +: 8] = q[rd_off + LANE_BITS'(i)];
    end
  end

endmodule

`default_nettype wire

[rtl/dram_open_row_timing_memory.sv]
// Byte-addressed 1 MiB memory with an open-row DRAM timing model. Each word on
// the input channel is a read or write of 1, 2 or 4 little-endian bytes at any
// byte alignment (addresses wrap at the top); each produces exactly one result
// word with the read data, the modeled latency, the row miss flag, a size error
// flag and running totals of time and precharges. A new word is accepted every
// cycle while the output is not stalled; each result passes through the
// registered read of the four byte-lane RAMs and then the output register.
// Timing registers may be written through the configuration channel while no
// access is in flight. Memory contents are undefined until written.
`default_nettype none
`include "assert_macros.svh"

module dram_open_row_timing_memory import dortm_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [19:0] addr,
  input  wire logic [31:0] write_data,
  input  wire logic [2:0]  size,
  input  wire logic [7:0]  burst_beats,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] read_data,
  output logic      [9:0]  latency,
  output logic             row_miss,
  output logic             size_error,
  output logic      [47:0] total_time,
  output logic      [31:0] precharges
);

  logic                 acc;
  logic                 advance;
  logic                 good;
  logic [ADDR_BITS-1:0] a;
  timing_res_t          tim;
  logic [31:0]          rdata;

  logic        s1_valid;
  timing_res_t s1_tim;
  logic        s1_err;

  assign cfg_ready = 1'b1;
  assign a       = addr[ADDR_BITS-1:0];
  assign good    = size == SIZE_BYTE || size == SIZE_HALF || size == SIZE_WORD;
  assign advance = !out_valid || out_ready;
  assign in_ready = !s1_valid || advance;
  assign acc     = in_valid && in_ready;

  dortm_timing u_timing (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .wr        (cmd),
    .row       (a[ADDR_BITS-1:COL_BITS]),
    .blen      (burst_beats),
    .res       (tim)
  );

  dortm_bytes u_bytes (
    .clk   (clk),
    .rst   (rst),
    .acc   (acc),
    .wr    (cmd),
    .addr  (a),
    .wdata (write_data),
    .size  (size),
    .good  (good),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (acc)          s1_valid <= 1'b1;
      else if (advance) s1_valid <= 1'b0;
      if (advance)      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_tim <= tim;
      s1_err <= !good;
    end
    if (advance && s1_valid) begin
      read_data  <= rdata;
      latency    <= s1_tim.latency;
      row_miss   <= s1_tim.row_miss;
      size_error <= s1_err;
      total_time <= s1_tim.total_time;
      precharges <= s1_tim.precharges;
    end
  end

  `ASSERT_NEXT(a_accept_fills_s1, clk, rst, acc, s1_valid)
  `ASSERT_NEXT(a_s1_holds, clk, rst, s1_valid && !advance, s1_valid && $stable(s1_tim))
  `ASSERT_IMPLIES(a_err_zero_data, clk, rst, out_valid && size_error, read_data == 32'd0)

endmodule

`default_nettype wire
